### rtl/lcgs_pkg.sv
package lcgs_pkg;

	localparam int PROD_W     = 47;
	localparam int SLOT_SHIFT = 37;
	localparam int QUOT_W     = PROD_W - SLOT_SHIFT;

	localparam logic [30:0] MOD_ONE   = 31'd2147483563;
	localparam logic [30:0] MOD_TWO   = 31'd2147483399;
	localparam logic [30:0] TOP_VALUE = 31'd2147483562;
	localparam logic [30:0] SEED_INIT = 31'd123456789;
	localparam logic [15:0] MUL_ONE   = 16'd40014;
	localparam logic [15:0] MUL_TWO   = 16'd40692;
	localparam logic [7:0]  FOLD_ONE  = 8'd85;
	localparam logic [7:0]  FOLD_TWO  = 8'd249;

	localparam logic ACT_DRAW = 1'b0;
	localparam logic ACT_SEED = 1'b1;

	typedef logic [3:0] pc_t;

	localparam pc_t P_IDLE  = 4'd0;
	localparam pc_t P_DRAW0 = 4'd1;
	localparam pc_t P_DRAW1 = 4'd2;
	localparam pc_t P_DRAW2 = 4'd3;
	localparam pc_t P_DRAW3 = 4'd4;
	localparam pc_t P_DRAW4 = 4'd5;
	localparam pc_t P_DRAW5 = 4'd6;
	localparam pc_t P_SEED0 = 4'd7;
	localparam pc_t P_SEED1 = 4'd8;
	localparam pc_t P_SEED2 = 4'd9;
	localparam pc_t P_SEED3 = 4'd10;

	typedef enum logic [1:0] {MA_G1, MA_G2, MA_LAST, MA_DIV} mul_a_t;
	typedef enum logic [1:0] {MB_A1, MB_A2, MB_RECIP, MB_QUOT} mul_b_t;
	typedef enum logic [1:0] {RD_NONE, RD_ONE, RD_TWO} red_t;
	typedef enum logic [1:0] {GS_HOLD, GS_SEED, GS_MOD} g_src_t;
	typedef enum logic [1:0] {JC_NEXT, JC_DISPATCH, JC_LOOP, JC_OUT} jc_t;

	typedef struct packed {
		logic   in_rdy;
		mul_a_t ma;
		mul_b_t mb;
		logic   mul_en;
		red_t   red;
		g_src_t g1;
		g_src_t g2;
		logic   q_ld;
		logic   slot_ld;
		logic   fin;
		logic   cnt_ld;
		logic   warm;
		jc_t    jc;
		pc_t    target;
	} ctrl_t;

	typedef struct packed {
		logic cnt_nz;
		logic out_free;
	} sts_t;

	localparam ctrl_t CTRL_NOP = '{
		in_rdy: 1'b0, ma: MA_G1, mb: MB_A1, mul_en: 1'b0, red: RD_NONE,
		g1: GS_HOLD, g2: GS_HOLD, q_ld: 1'b0, slot_ld: 1'b0, fin: 1'b0,
		cnt_ld: 1'b0, warm: 1'b0, jc: JC_NEXT, target: P_IDLE
	};

	function automatic ctrl_t prog_rom(pc_t pc);
		ctrl_t w;
		w = CTRL_NOP;
		case (pc)
			P_IDLE: begin
				w.in_rdy = 1'b1;
				w.jc     = JC_DISPATCH;
				w.target = P_SEED0;
			end
			P_DRAW0: begin
				w.mul_en = 1'b1;
				w.ma     = MA_G1;
				w.mb     = MB_A1;
			end
			P_DRAW1: begin
				w.red    = RD_ONE;
				w.mul_en = 1'b1;
				w.ma     = MA_G2;
				w.mb     = MB_A2;
			end
			P_DRAW2: begin
				w.g1     = GS_MOD;
				w.red    = RD_TWO;
				w.mul_en = 1'b1;
				w.ma     = MA_LAST;
				w.mb     = MB_RECIP;
			end
			P_DRAW3: begin
				w.g2     = GS_MOD;
				w.q_ld   = 1'b1;
				w.mul_en = 1'b1;
				w.ma     = MA_DIV;
				w.mb     = MB_QUOT;
			end
			P_DRAW4: begin
				w.slot_ld = 1'b1;
			end
			P_DRAW5: begin
				w.fin    = 1'b1;
				w.jc     = JC_OUT;
				w.target = P_IDLE;
			end
			P_SEED0: begin
				w.g1     = GS_SEED;
				w.g2     = GS_SEED;
				w.cnt_ld = 1'b1;
			end
			P_SEED1: begin
				w.mul_en = 1'b1;
				w.ma     = MA_G1;
				w.mb     = MB_A1;
			end
			P_SEED2: begin
				w.red = RD_ONE;
			end
			P_SEED3: begin
				w.g1     = GS_MOD;
				w.warm   = 1'b1;
				w.jc     = JC_LOOP;
				w.target = P_SEED1;
			end
			default: begin
				w.jc     = JC_OUT;
				w.target = P_IDLE;
			end
		endcase
		return w;
	endfunction

endpackage

### rtl/lcgs_if.sv
interface lcgs_cmd_if;
	logic               valid;
	logic               ready;
	logic               action;
	logic signed [31:0] seed;

	modport source (output valid, output action, output seed, input ready);
	modport sink (input valid, input action, input seed, output ready);
endinterface

interface lcgs_rsp_if;
	logic        valid;
	logic        ready;
	logic [30:0] value;

	modport source (output valid, output value, input ready);
	modport sink (input valid, input value, output ready);
endinterface

### rtl/lcgs_ram.sv
module lcgs_ram #(
	parameter int WIDTH = 31,
	parameter int DEPTH = 32
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/lcgs_seq.sv
module lcgs_seq (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	input  logic           cmd_action,
	input  lcgs_pkg::sts_t sts,
	output lcgs_pkg::ctrl_t ctrl
);
	import lcgs_pkg::*;

	pc_t pc_q;
	pc_t pc_next;

	assign ctrl = prog_rom(pc_q);

	always_comb begin
		case (ctrl.jc)
			JC_NEXT:     pc_next = pc_q + 4'd1;
			JC_DISPATCH: pc_next = cmd_valid
				? ((cmd_action == ACT_SEED) ? ctrl.target : pc_q + 4'd1) : pc_q;
			JC_LOOP:     pc_next = sts.cnt_nz ? ctrl.target : P_IDLE;
			JC_OUT:      pc_next = sts.out_free ? ctrl.target : pc_q;
			default:     pc_next = P_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= P_IDLE;
		end else begin
			pc_q <= pc_next;
		end
	end

`ifndef SYNTHESIS
	a_pc_range: assert property (@(posedge clk) disable iff (!arst_n)
		pc_q <= P_SEED3)
		else $error("step counter outside program");
	a_draw_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(pc_q == P_IDLE && cmd_valid && cmd_action == ACT_DRAW) |=> pc_q == P_DRAW0)
		else $error("draw transfer did not start draw program");
	a_warm_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(pc_q == P_SEED3 && !sts.cnt_nz) |=> pc_q == P_IDLE)
		else $error("warm-up did not end at last pass");
`endif

endmodule

### rtl/lcgs_dp.sv
module lcgs_dp #(
	parameter int TABLE_SIZE = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  lcgs_pkg::ctrl_t    ctrl,
	input  logic signed [31:0] seed,
	input  logic               out_ready,
	output logic               out_valid,
	output logic [30:0]        out_value,
	output lcgs_pkg::sts_t     sts
);
	import lcgs_pkg::*;

	localparam int AW = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
	localparam int CW = $clog2(TABLE_SIZE + 8);
	localparam longint unsigned SLOT_DIV = 64'd1 + 64'd2147483562 / TABLE_SIZE;
	localparam longint unsigned RECIP = (64'd1 << SLOT_SHIFT) / SLOT_DIV;
	localparam logic [30:0] DIV_C = 31'(SLOT_DIV);
	localparam logic [15:0] RECIP_C = 16'(RECIP);
	localparam logic [AW-1:0] SLOT_MAX = AW'(TABLE_SIZE - 1);

	logic [30:0]        g1_q, g2_q, last_q;
	logic [31:0]        seed_q;
	logic [PROD_W-1:0]  prod_q;
	logic [31:0]        red_q;
	logic [QUOT_W-1:0]  q_q;
	logic [AW-1:0]      slot_q;
	logic [CW-1:0]      cnt_q;
	logic [TABLE_SIZE-1:0] vld_q;
	logic               out_vld_q;
	logic [30:0]        out_val_q;

	logic [30:0] ma_v;
	logic [15:0] mb_v;
	logic [23:0] fold_prod;
	logic [7:0]  fold;
	logic [31:0] sub_one, sub_two;
	logic [30:0] mod_one, mod_two;
	logic [31:0] neg;
	logic [30:0] mag_raw, mag;
	logic [30:0] rem;
	logic [AW:0] slot_full_w;
	logic [QUOT_W:0] slot_full;
	logic [AW-1:0] slot_next;
	logic [30:0] rdata, tbl;
	logic [32:0] d0, d1;
	logic [30:0] val;
	logic        fin_go;
	logic        warm_wr;
	logic        we;
	logic [AW-1:0] waddr;
	logic [30:0] wdata;

	always_comb begin
		case (ctrl.ma)
			MA_G1:   ma_v = g1_q;
			MA_G2:   ma_v = g2_q;
			MA_LAST: ma_v = last_q;
			MA_DIV:  ma_v = DIV_C;
			default: ma_v = g1_q;
		endcase
		case (ctrl.mb)
			MB_A1:    mb_v = MUL_ONE;
			MB_A2:    mb_v = MUL_TWO;
			MB_RECIP: mb_v = RECIP_C;
			MB_QUOT:  mb_v = {{(16 - QUOT_W){1'b0}}, prod_q[PROD_W-1:SLOT_SHIFT]};
			default:  mb_v = MUL_ONE;
		endcase
	end

	assign fold = (ctrl.red == RD_TWO) ? FOLD_TWO : FOLD_ONE;
	assign fold_prod = {8'b0, prod_q[PROD_W-1:31]} * {16'b0, fold};

	assign sub_one = red_q - {1'b0, MOD_ONE};
	assign sub_two = red_q - {1'b0, MOD_TWO};
	assign mod_one = (red_q >= {1'b0, MOD_ONE}) ? sub_one[30:0] : red_q[30:0];
	assign mod_two = (red_q >= {1'b0, MOD_TWO}) ? sub_two[30:0] : red_q[30:0];

	assign neg     = ~seed_q + 32'd1;
	assign mag_raw = seed_q[31] ? (neg[31] ? 31'h7FFF_FFFF : neg[30:0]) : seed_q[30:0];
	assign mag     = (mag_raw == 31'd0) ? 31'd1 : mag_raw;

	assign rem       = last_q - prod_q[30:0];
	assign slot_full = {1'b0, q_q} + {{QUOT_W{1'b0}}, (rem >= DIV_C)};
	assign slot_full_w = (slot_full > (QUOT_W + 1)'(TABLE_SIZE - 1))
		? {1'b0, SLOT_MAX} : (AW + 1)'(slot_full);
	assign slot_next = slot_full_w[AW-1:0];

	assign tbl = vld_q[slot_q] ? rdata : 31'd0;
	assign d0  = {2'b00, tbl} - {2'b00, g2_q};
	assign d1  = ($signed(d0) < 33'sd1) ? d0 + {2'b00, TOP_VALUE} : d0;
	assign val = ($signed(d1) < 33'sd1) ? 31'd1
		: ($signed(d1) > $signed({2'b00, TOP_VALUE})) ? TOP_VALUE : d1[30:0];

	assign sts.out_free = !out_vld_q || out_ready;
	assign sts.cnt_nz   = (cnt_q != '0);
	assign fin_go       = ctrl.fin && sts.out_free;
	assign warm_wr      = ctrl.warm && (cnt_q < CW'(TABLE_SIZE));

	assign we    = fin_go || warm_wr;
	assign waddr = ctrl.warm ? cnt_q[AW-1:0] : slot_q;
	assign wdata = ctrl.warm ? mod_one : g1_q;

	lcgs_ram #(
		.WIDTH(31),
		.DEPTH(TABLE_SIZE)
	) u_table (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (ctrl.slot_ld),
		.raddr(slot_next),
		.rdata(rdata)
	);

	always_ff @(posedge clk) begin
		if (ctrl.in_rdy) begin
			seed_q <= seed;
		end
		if (ctrl.mul_en) begin
			prod_q <= {16'b0, ma_v} * {31'b0, mb_v};
		end
		if (ctrl.red != RD_NONE) begin
			red_q <= {8'b0, fold_prod} + {1'b0, prod_q[30:0]};
		end
		if (ctrl.q_ld) begin
			q_q <= prod_q[PROD_W-1:SLOT_SHIFT];
		end
		if (ctrl.slot_ld) begin
			slot_q <= slot_next;
		end
		if (ctrl.cnt_ld) begin
			cnt_q <= CW'(TABLE_SIZE + 7);
		end else if (ctrl.warm) begin
			cnt_q <= cnt_q - CW'(1);
		end
		if (fin_go) begin
			out_val_q <= val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			g1_q      <= 31'd0;
			g2_q      <= SEED_INIT;
			last_q    <= 31'd0;
			vld_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			case (ctrl.g1)
				GS_SEED: g1_q <= mag;
				GS_MOD:  g1_q <= mod_one;
				default: g1_q <= g1_q;
			endcase
			case (ctrl.g2)
				GS_SEED: g2_q <= mag;
				GS_MOD:  g2_q <= mod_two;
				default: g2_q <= g2_q;
			endcase
			if (ctrl.warm && !sts.cnt_nz) begin
				last_q <= mod_one;
			end else if (fin_go) begin
				last_q <= val;
			end
			if (we) begin
				vld_q[waddr] <= 1'b1;
			end
			if (fin_go) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_vld_q;
	assign out_value = out_val_q;

`ifndef SYNTHESIS
	a_value_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q |-> (out_val_q != 31'd0 && out_val_q <= TOP_VALUE))
		else $error("result outside 1..TOP_VALUE");
	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.slot_ld |=> slot_q <= SLOT_MAX)
		else $error("slot index beyond table");
	a_gen_one_mod: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.g1 == GS_MOD) |=> g1_q < MOD_ONE)
		else $error("first generator not reduced");
`endif

endmodule

### rtl/combined_lcg_shuffle_rng_top.sv
// channel | dir | payload                      | transfer
// cmd     | in  | action (1b), seed (32b, s)   | valid && ready
// rsp     | out | value (31b)                  | valid && ready
//
// Draw: a new command is taken only back in idle; steps DRAW0-DRAW3 each use a shared 31x16 multiplier.
// Reseed: TABLE_SIZE+8 warm-up passes of the first generator, no result.
// Reset zeroes the first generator and last output, loads the second
// generator with its start value and clears per-entry valid bits;
// unwritten table entries read as zero.
// Final draw step holds while the result register is full and not taken.
module combined_lcg_shuffle_rng_top #(
	parameter int TABLE_SIZE = 32
) (
	input logic         clk,
	input logic         arst_n,
	lcgs_cmd_if.sink    cmd,
	lcgs_rsp_if.source  rsp
);
	import lcgs_pkg::*;

	ctrl_t ctrl;
	sts_t  sts;

	lcgs_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd.valid),
		.cmd_action(cmd.action),
		.sts       (sts),
		.ctrl      (ctrl)
	);

	lcgs_dp #(
		.TABLE_SIZE(TABLE_SIZE)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ctrl),
		.seed     (cmd.seed),
		.out_ready(rsp.ready),
		.out_valid(rsp.valid),
		.out_value(rsp.value),
		.sts      (sts)
	);

	assign cmd.ready = ctrl.in_rdy;

endmodule

### dv/lcgs_draw_checker.sv
`timescale 1ns / 1ps
module lcgs_draw_checker (
	input  logic clk,
	input  logic arst_n,
	lcgs_cmd_if  cmd,
	lcgs_rsp_if  rsp,
	output int   fails,
	output int   outstanding,
	output int   draws_seen,
	output int   reseeds_seen
);
	import lcgs_pkg::*;

	localparam int          SLOTS    = 32;
	localparam logic [30:0] SLOT_DIV = 31'(TOP_VALUE / SLOTS) + 31'd1;

	logic [30:0] g1_state;
	logic [30:0] g2_state;
	logic [30:0] last_val;
	logic [30:0] shuf [SLOTS];
	logic [30:0] pending_values [$];

	function automatic logic [30:0] mul_mod(logic [30:0] x, logic [15:0] a, logic [30:0] m);
		logic [63:0] prod;
		prod = 64'(x) * 64'(a);
		return 31'(prod % 64'(m));
	endfunction

	task automatic clear_state();
		g1_state = '0;
		g2_state = SEED_INIT;
		last_val = '0;
		for (int i = 0; i < SLOTS; i++) begin
			shuf[i] = '0;
		end
	endtask

	task automatic load_seed(input logic signed [31:0] raw);
		logic [31:0] mag;
		if (raw[31]) begin
			mag = ~raw + 32'd1;
			if (mag > 32'h7FFF_FFFF) begin
				mag = 32'h7FFF_FFFF;
			end
		end else begin
			mag = raw;
		end
		if (mag == 32'd0) begin
			mag = 32'd1;
		end
		g1_state = mag[30:0];
		g2_state = mag[30:0];
		for (int j = SLOTS + 7; j >= 0; j--) begin
			g1_state = mul_mod(g1_state, MUL_ONE, MOD_ONE);
			if (j < SLOTS) begin
				shuf[j] = g1_state;
			end
		end
		last_val = shuf[0];
	endtask

	task automatic draw_next(output logic [30:0] value);
		int          slot;
		logic [30:0] quot;
		longint      diff;
		longint      entry;
		longint      top_l;
		g1_state = mul_mod(g1_state, MUL_ONE, MOD_ONE);
		g2_state = mul_mod(g2_state, MUL_TWO, MOD_TWO);
		quot = last_val / SLOT_DIV;
		slot = (quot >= SLOTS) ? SLOTS - 1 : int'(quot);
		entry = longint'(shuf[slot]);
		top_l = longint'(TOP_VALUE);
		diff = entry - longint'(g2_state);
		shuf[slot] = g1_state;
		if (diff < 1) begin
			diff = diff + top_l;
		end
		if (diff < 1) begin
			diff = 1;
		end
		if (diff > top_l) begin
			diff = top_l;
		end
		last_val = diff[30:0];
		value = last_val;
	endtask

	initial begin
		clear_state();
	end

	always @(posedge clk) begin : watch
		logic [30:0] want;
		if (!arst_n) begin
			clear_state();
			pending_values.delete();
			fails        <= 0;
			draws_seen   <= 0;
			reseeds_seen <= 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (pending_values.size() == 0) begin
					fails <= fails + 1;
					$display("%0t: unexpected result, expected none, got %0d", $time, rsp.value);
				end else begin
					want = pending_values.pop_front();
					draws_seen <= draws_seen + 1;
					if (rsp.value !== want) begin
						fails <= fails + 1;
						$display("%0t: value mismatch, expected %0d, got %0d",
							$time, want, rsp.value);
					end
				end
			end
			if (cmd.valid && cmd.ready) begin
				if (cmd.action == ACT_SEED) begin
					load_seed(cmd.seed);
					reseeds_seen <= reseeds_seen + 1;
				end else begin
					draw_next(want);
					pending_values.push_back(want);
				end
			end
		end
		outstanding <= pending_values.size();
	end

endmodule

### dv/tb_combined_lcg_shuffle_rng_top.sv
`timescale 1ns / 1ps
module tb_combined_lcg_shuffle_rng_top;
	import lcgs_pkg::*;

	localparam int   PHASE_LEN  = 163;
	localparam int   DRAIN_WAIT = 130;

	logic clk;
	logic arst_n;
	int   send_idle_pct;
	int   recv_stall_pct;
	int   fails;
	int   outstanding;
	int   draws_seen;
	int   reseeds_seen;

	lcgs_cmd_if cmd_bus ();
	lcgs_rsp_if rsp_bus ();

	combined_lcg_shuffle_rng_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_bus),
		.rsp    (rsp_bus)
	);

	lcgs_draw_checker checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd_bus),
		.rsp          (rsp_bus),
		.fails        (fails),
		.outstanding  (outstanding),
		.draws_seen   (draws_seen),
		.reseeds_seen (reseeds_seen)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	always @(negedge clk) begin
		rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	initial begin
		#4_000_000;
		$display("tb_combined_lcg_shuffle_rng_top: FAIL");
		$finish;
	end

	task automatic push_cmd(input logic act, input logic signed [31:0] sd);
		while ($urandom_range(99) < send_idle_pct) begin
			@(negedge clk);
			cmd_bus.valid <= 1'b0;
		end
		@(negedge clk);
		cmd_bus.valid  <= 1'b1;
		cmd_bus.action <= act;
		cmd_bus.seed   <= sd;
		do begin
			@(posedge clk);
		end while (!cmd_bus.ready);
	endtask

	function automatic logic signed [31:0] pick_seed();
		logic signed [31:0] s;
		case ($urandom_range(5))
			0: s = $urandom_range(1000);
			1: s = -$signed(32'($urandom_range(1000)));
			2: s = $signed(32'(MOD_ONE)) + $signed(32'($urandom_range(6))) - 32'sd3;
			3: s = $signed(32'(MOD_TWO)) + $signed(32'($urandom_range(6))) - 32'sd3;
			4: begin
				case ($urandom_range(3))
					0: s = 32'sd0;
					1: s = 32'sh8000_0000;
					2: s = 32'sh7FFF_FFFF;
					default: s = -32'sh7FFF_FFFF;
				endcase
			end
			default: s = $urandom;
		endcase
		return s;
	endfunction

	initial begin : stim
		arst_n         = 1'b0;
		cmd_bus.valid  = 1'b0;
		cmd_bus.action = ACT_DRAW;
		cmd_bus.seed   = '0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// draws on the reset state, then edge seeds
		repeat (3) push_cmd(ACT_DRAW, $urandom);
		push_cmd(ACT_SEED, 32'sd0);
		repeat (2) push_cmd(ACT_DRAW, $urandom);
		push_cmd(ACT_SEED, 32'sh8000_0000);
		push_cmd(ACT_DRAW, 32'sh7FFF_FFFF);
		push_cmd(ACT_SEED, 32'sh7FFF_FFFF);
		push_cmd(ACT_DRAW, 32'sh8000_0000);
		push_cmd(ACT_SEED, -32'sh7FFF_FFFF);
		push_cmd(ACT_DRAW, 32'sd0);
		push_cmd(ACT_SEED, $signed(32'(MOD_ONE)));
		repeat (2) push_cmd(ACT_DRAW, -32'sd1);
		push_cmd(ACT_SEED, $signed(32'(MOD_TWO)));
		push_cmd(ACT_DRAW, $urandom);
		push_cmd(ACT_SEED, 32'sd1);
		push_cmd(ACT_DRAW, $urandom);
		push_cmd(ACT_SEED, -32'sd1);
		push_cmd(ACT_DRAW, $urandom);

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
				default: begin send_idle_pct = 8; recv_stall_pct = 8; end
			endcase
			repeat (PHASE_LEN) begin
				if ($urandom_range(99) < 7) begin
					push_cmd(ACT_SEED, pick_seed());
				end else begin
					push_cmd(ACT_DRAW, $urandom);
				end
			end
		end
		@(negedge clk);
		cmd_bus.valid <= 1'b0;
		recv_stall_pct = 0;

		while (outstanding != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("checked %0d draws across %0d reseeds, including edge seeds", draws_seen,
			reseeds_seen);
		$display("pacing: free-running, sender gaps, receiver stalls, light mixed idling");
		if (fails == 0) begin
			$display("tb_combined_lcg_shuffle_rng_top: PASS");
		end else begin
			$display("tb_combined_lcg_shuffle_rng_top: FAIL");
		end
		$finish;
	end

endmodule

### files.f
rtl/lcgs_pkg.sv
rtl/lcgs_if.sv
rtl/lcgs_ram.sv
rtl/lcgs_seq.sv
rtl/lcgs_dp.sv
rtl/combined_lcg_shuffle_rng_top.sv
dv/lcgs_draw_checker.sv
dv/tb_combined_lcg_shuffle_rng_top.sv
